/* hdl/ghd_pkg.sv */
// Shared types, constants and gain tables for the gyro heading hold drive unit.
package ghd_pkg;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Yaw accumulator: Q27.20 degrees
    localparam int ACC_W     = 48;
    localparam int FRAC_BITS = 20;

    localparam int HEAD_W = 16;
    localparam int ERR_W  = 17;
    localparam int GAIN_W = 17;

    // Q1.15 unity, held wide enough for both operand ports
    localparam logic signed [MUL_B_W-1:0] ONE_Q15 = 18'sd32768;

    localparam int STRAIGHT_CLAMP_ERR = 4;
    localparam int TURN_CLAMP_ERR     = 18;

    // Sequencer steps
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE,
        ST_ACCUM,
        ST_HEAD,
        ST_ERROR,
        ST_LEFT,
        ST_RIGHT,
        ST_OUT
    } state_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic                        en;
        logic signed [MUL_A_W-1:0]   a;
        logic signed [MUL_B_W-1:0]   b;
    } mul_req_t;

    // |error| * 7/25 in Q1.15, truncated, clamped to 1.0
    function automatic logic [GAIN_W-1:0] straight_gain(input logic [ERR_W-1:0] err_mag);
        logic [GAIN_W-1:0] g;
        begin
            if (err_mag >= ERR_W'(STRAIGHT_CLAMP_ERR)) begin
                g = 17'd32768;
            end else begin
                case (err_mag[1:0])
                    2'd0:    g = 17'd0;
                    2'd1:    g = 17'd9175;
                    2'd2:    g = 17'd18350;
                    default: g = 17'd27525;
                endcase
            end
            return g;
        end
    endfunction

    // |error| / 18 in Q1.15, truncated, clamped to 1.0; a nonzero value
    // below 0.15 is already raised to 0.15 in the table
    function automatic logic [GAIN_W-1:0] turn_gain(input logic [ERR_W-1:0] err_mag);
        logic [GAIN_W-1:0] g;
        begin
            if (err_mag >= ERR_W'(TURN_CLAMP_ERR)) begin
                g = 17'd32768;
            end else begin
                case (err_mag[4:0])
                    5'd1:    g = 17'd4915;
                    5'd2:    g = 17'd4915;
                    5'd3:    g = 17'd5461;
                    5'd4:    g = 17'd7281;
                    5'd5:    g = 17'd9102;
                    5'd6:    g = 17'd10922;
                    5'd7:    g = 17'd12743;
                    5'd8:    g = 17'd14563;
                    5'd9:    g = 17'd16384;
                    5'd10:   g = 17'd18204;
                    5'd11:   g = 17'd20024;
                    5'd12:   g = 17'd21845;
                    5'd13:   g = 17'd23665;
                    5'd14:   g = 17'd25486;
                    5'd15:   g = 17'd27306;
                    5'd16:   g = 17'd29127;
                    5'd17:   g = 17'd30947;
                    default: g = 17'd0;
                endcase
            end
            return g;
        end
    endfunction

endpackage

/* hdl/gyro_heading_hold_drive_unit.sv */
// Top level: heading-hold controller for a differential drive, sequenced over one multiplier.
// Requests are handled one at a time: the single shared multiplier is used for the
// yaw increment and then for each of the two side products in turn.
// s_tready is low while a request is in progress; a finished result waits in the output
// register while the next request is taken. Reset (aresetn low, synchronous) clears the
// yaw accumulator, loads time_step with 655 and empties the output register.
module gyro_heading_hold_drive_unit #(
    parameter int DUTY_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,

    // Configuration: time_step, Q0.16 seconds
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,

    input  logic                s_tvalid,
    output logic                s_tready,
    // [15:0] gyro_rate, [31:16] throttle, [47:32] target_angle
    input  logic [47:0]         s_tdata,
    // [0] op (0 straight, 1 turn)
    input  logic                s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // from bit 0 up: left_forward_duty, left_reverse_duty, right_forward_duty,
    // right_reverse_duty (DUTY_BITS each), heading (16), turn_done (1), zero pad
    output logic [((4*DUTY_BITS+ghd_pkg::HEAD_W+1+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_W = ((4*DUTY_BITS + ghd_pkg::HEAD_W + 1 + 7) / 8) * 8;
    localparam int NEG_W = ghd_pkg::ACC_W + 1;
    localparam int QUO_W = NEG_W - ghd_pkg::FRAC_BITS;

    localparam logic [15:0] TIME_STEP_RESET = 16'd655;

    localparam logic signed [QUO_W-1:0] HEAD_MAX = QUO_W'(32767);
    localparam logic signed [QUO_W-1:0] HEAD_MIN = -QUO_W'(32768);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    ghd_pkg::state_t state_reg, state_next;

    logic [15:0]                                  time_step_reg, time_step_next;
    logic signed [ghd_pkg::ACC_W-1:0]             acc_reg, acc_next;

    // captured request
    logic                                         op_reg, op_next;
    logic signed [15:0]                           rate_reg, rate_next;
    logic signed [15:0]                           thr_reg, thr_next;
    logic signed [15:0]                           target_reg, target_next;

    logic signed [ghd_pkg::HEAD_W-1:0]            heading_reg, heading_next;
    logic signed [ghd_pkg::GAIN_W-1:0]            gain_reg, gain_next;
    logic                                         done_reg, done_next;
    logic [DUTY_BITS-1:0]                         lf_reg, lf_next;
    logic [DUTY_BITS-1:0]                         lr_reg, lr_next;

    logic                                         m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]                             m_data_reg, m_data_next;

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    ghd_pkg::mul_req_t                            mul_req;
    logic signed [ghd_pkg::PROD_W-1:0]            prod;
    logic [DUTY_BITS-1:0]                         fwd_duty;
    logic [DUTY_BITS-1:0]                         rev_duty;

    ghd_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    // One converter serves both sides: left in ST_RIGHT, right in ST_OUT
    ghd_duty #(
        .DUTY_BITS (DUTY_BITS)
    ) u_duty (
        .side     (prod),
        .fwd_duty (fwd_duty),
        .rev_duty (rev_duty)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic signed [NEG_W-1:0]          neg_yaw;
    logic signed [QUO_W-1:0]          head_quot;
    logic signed [ghd_pkg::ERR_W-1:0] err;
    logic [ghd_pkg::ERR_W-1:0]        err_mag;
    logic [ghd_pkg::GAIN_W-1:0]       gain_mag;
    logic signed [ghd_pkg::MUL_B_W-1:0] gain_wide;
    logic signed [ghd_pkg::MUL_B_W-1:0] one_plus;
    logic signed [ghd_pkg::MUL_B_W-1:0] one_minus;
    logic                             thr_pos;

    always_comb begin
        // Heading: negated yaw divided by 2^20, truncated toward zero
        neg_yaw = -NEG_W'(acc_reg);
        if (neg_yaw[NEG_W-1]) begin
            head_quot = QUO_W'((neg_yaw + NEG_W'((1 << ghd_pkg::FRAC_BITS) - 1))
                               >>> ghd_pkg::FRAC_BITS);
        end else begin
            head_quot = QUO_W'(neg_yaw >>> ghd_pkg::FRAC_BITS);
        end

        // Error and proportional gain
        err      = ghd_pkg::ERR_W'(target_reg) - ghd_pkg::ERR_W'(heading_reg);
        err_mag  = err[ghd_pkg::ERR_W-1] ? ghd_pkg::ERR_W'(-err) : ghd_pkg::ERR_W'(err);
        gain_mag = op_reg ? ghd_pkg::turn_gain(err_mag) : ghd_pkg::straight_gain(err_mag);

        gain_wide = ghd_pkg::MUL_B_W'(gain_reg);
        one_plus  = ghd_pkg::ONE_Q15 + gain_wide;
        one_minus = ghd_pkg::ONE_Q15 - gain_wide;
        thr_pos   = !thr_reg[15] && (thr_reg != '0);
    end

    // ------------------------------------------------------------------
    // Sequencer: next state, datapath updates and multiplier requests
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        time_step_next = time_step_reg;
        acc_next       = acc_reg;
        op_next        = op_reg;
        rate_next      = rate_reg;
        thr_next       = thr_reg;
        target_next    = target_reg;
        heading_next   = heading_reg;
        gain_next      = gain_reg;
        done_next      = done_reg;
        lf_next        = lf_reg;
        lr_next        = lr_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        mul_req.en = 1'b0;
        mul_req.a  = ghd_pkg::MUL_A_W'(rate_reg);
        mul_req.b  = ghd_pkg::MUL_B_W'({1'b0, time_step_reg});

        s_tready = (state_reg == ghd_pkg::ST_IDLE);

        if (cfg_wr_en) begin
            time_step_next = cfg_wr_data;
        end

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ghd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    rate_next   = s_tdata[15:0];
                    thr_next    = s_tdata[31:16];
                    target_next = s_tdata[47:32];
                    state_next  = ghd_pkg::ST_RATE;
                end
            end
            ghd_pkg::ST_RATE: begin
                // rate * time_step
                mul_req.en = 1'b1;
                state_next = ghd_pkg::ST_ACCUM;
            end
            ghd_pkg::ST_ACCUM: begin
                // wraps modulo 2^48
                acc_next   = acc_reg + ghd_pkg::ACC_W'(prod);
                state_next = ghd_pkg::ST_HEAD;
            end
            ghd_pkg::ST_HEAD: begin
                if (head_quot > HEAD_MAX) begin
                    heading_next = 16'sh7fff;
                end else if (head_quot < HEAD_MIN) begin
                    heading_next = 16'sh8000;
                end else begin
                    heading_next = head_quot[ghd_pkg::HEAD_W-1:0];
                end
                state_next = ghd_pkg::ST_ERROR;
            end
            ghd_pkg::ST_ERROR: begin
                gain_next  = err[ghd_pkg::ERR_W-1] ? ghd_pkg::GAIN_W'(-gain_mag) : gain_mag;
                done_next  = op_reg && (err == '0);
                state_next = ghd_pkg::ST_LEFT;
            end
            ghd_pkg::ST_LEFT: begin
                mul_req.en = 1'b1;
                if (op_reg) begin
                    mul_req.a = gain_reg;
                    mul_req.b = ghd_pkg::ONE_Q15;
                end else begin
                    mul_req.a = ghd_pkg::MUL_A_W'(thr_reg);
                    mul_req.b = thr_pos ? one_plus : one_minus;
                end
                state_next = ghd_pkg::ST_RIGHT;
            end
            ghd_pkg::ST_RIGHT: begin
                // product register still holds the left side value
                lf_next    = fwd_duty;
                lr_next    = rev_duty;
                mul_req.en = 1'b1;
                if (op_reg) begin
                    mul_req.a = gain_reg;
                    mul_req.b = -ghd_pkg::ONE_Q15;
                end else begin
                    mul_req.a = ghd_pkg::MUL_A_W'(thr_reg);
                    mul_req.b = thr_pos ? one_minus : one_plus;
                end
                state_next = ghd_pkg::ST_OUT;
            end
            ghd_pkg::ST_OUT: begin
                // Hold here while an earlier result still waits
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_W'({done_reg, heading_reg, rev_duty, fwd_duty,
                                           lr_reg, lf_reg});
                    state_next   = ghd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ghd_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ghd_pkg::ST_IDLE;
            time_step_reg <= TIME_STEP_RESET;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            time_step_reg <= time_step_next;
            acc_reg       <= acc_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        rate_reg    <= rate_next;
        thr_reg     <= thr_next;
        target_reg  <= target_next;
        heading_reg <= heading_next;
        gain_reg    <= gain_next;
        done_reg    <= done_next;
        lf_reg      <= lf_next;
        lr_reg      <= lr_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Yaw moves only in the accumulate step
    a_acc_only_in_accum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ghd_pkg::ST_ACCUM) |=> $stable(acc_reg))
        else $error("yaw accumulator changed outside the accumulate step");

    // An accepted request starts the sequence and blocks further requests
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && state_reg == ghd_pkg::ST_RATE))
        else $error("sequencer did not start after a request was accepted");

    // A completed turn drives nothing
    a_done_means_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4*DUTY_BITS+ghd_pkg::HEAD_W]) |->
            (m_tdata[4*DUTY_BITS-1:0] == '0))
        else $error("turn_done set with nonzero duty");

    // Never drive both bridge legs of one side
    a_one_leg_per_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            ((m_tdata[DUTY_BITS-1:0] == '0) || (m_tdata[2*DUTY_BITS-1:DUTY_BITS] == '0)) &&
            ((m_tdata[3*DUTY_BITS-1:2*DUTY_BITS] == '0) ||
             (m_tdata[4*DUTY_BITS-1:3*DUTY_BITS] == '0)))
        else $error("forward and reverse duty both nonzero on one side");

endmodule

/* hdl/ghd_mul.sv */
// Shared signed multiplier with a registered product.
module ghd_mul (
    input  logic                                aclk,
    input  ghd_pkg::mul_req_t                   req,
    output logic signed [ghd_pkg::PROD_W-1:0]   prod
);

    logic signed [ghd_pkg::PROD_W-1:0] prod_reg;
    logic signed [ghd_pkg::PROD_W-1:0] prod_next;

    always_comb begin
        prod_next = req.a * req.b;
    end

    // Hold the product until the next request
    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* hdl/ghd_duty.sv */
// Converts one Q2.30 side value into a saturated forward/reverse duty pair.
module ghd_duty #(
    parameter int DUTY_BITS = 8
) (
    input  logic signed [ghd_pkg::PROD_W-1:0] side,
    output logic        [DUTY_BITS-1:0]       fwd_duty,
    output logic        [DUTY_BITS-1:0]       rev_duty
);

    localparam int SCALED_W = ghd_pkg::PROD_W + DUTY_BITS;
    localparam int QUOT_W   = SCALED_W - 30;

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

    logic [ghd_pkg::PROD_W-1:0] mag;
    logic [SCALED_W-1:0]        scaled;
    logic [QUOT_W-1:0]          quot;
    logic [DUTY_BITS-1:0]       duty;

    always_comb begin
        mag    = side[ghd_pkg::PROD_W-1] ? ghd_pkg::PROD_W'(-side) : ghd_pkg::PROD_W'(side);
        // mag * (2^DUTY_BITS - 1) as shift and subtract
        scaled = {mag, {DUTY_BITS{1'b0}}} - SCALED_W'(mag);
        quot   = scaled[SCALED_W-1:30];
        duty   = (quot > QUOT_W'(DUTY_MAX)) ? DUTY_MAX : quot[DUTY_BITS-1:0];

        fwd_duty = '0;
        rev_duty = '0;
        if (side[ghd_pkg::PROD_W-1]) begin
            rev_duty = duty;
        end else if (side != '0) begin
            fwd_duty = duty;
        end
    end

endmodule

/* verif/gyro_heading_hold_drive_unit_tb.sv */
// Self-checking testbench for the gyro heading hold drive unit: directed and random control ticks.
module gyro_heading_hold_drive_unit_tb;

    localparam int DUTY_BITS = 8;
    localparam int RES_W     = ((4*DUTY_BITS + ghd_pkg::HEAD_W + 1 + 7) / 8) * 8;
    localparam int ACC_W     = ghd_pkg::ACC_W;

    // Mode carried on s_tuser
    localparam logic OP_STRAIGHT = 1'b0;
    localparam logic OP_TURN     = 1'b1;

    // Q1.15 unity, smallest spin command and full-scale duty
    localparam longint UNITY    = 32768;
    localparam longint MIN_SPIN = 4915;
    localparam longint DUTY_MAX = (longint'(1) << DUTY_BITS) - 1;
    localparam longint HEAD_MAX = 32767;
    localparam longint HEAD_MIN = -32768;

    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PER_SET = 110;
    localparam int SPIN_UP        = 40;
    localparam int SPIN_BACK      = 80;

    // Result fields, last field in the lowest bits as on m_tdata
    typedef struct packed {
        logic                        done;
        logic signed [15:0]          heading;
        logic [DUTY_BITS-1:0]        right_rev;
        logic [DUTY_BITS-1:0]        right_fwd;
        logic [DUTY_BITS-1:0]        left_rev;
        logic [DUTY_BITS-1:0]        left_fwd;
    } drive_result_t;

    // Heading/drive predictor with its own yaw accumulator and time step
    class drive_scoreboard;
        logic [ACC_W-1:0] yaw_acc;
        logic [15:0]      step_size;
        drive_result_t    expected_q[$];
        int               errors;

        function new();
            yaw_acc   = '0;
            step_size = 16'd655;
            errors    = 0;
        endfunction

        function void set_step(logic [15:0] v);
            step_size = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [ACC_W-1:0] advance(logic [ACC_W-1:0] acc, logic signed [15:0] rate);
            return acc + ACC_W'(longint'(rate) * longint'(step_size));
        endfunction

        function longint heading_of(logic [ACC_W-1:0] acc);
            longint yaw;
            longint hd;
            yaw = longint'($signed(acc));
            hd  = -yaw / (longint'(1) << ghd_pkg::FRAC_BITS);
            if (hd > HEAD_MAX) hd = HEAD_MAX;
            if (hd < HEAD_MIN) hd = HEAD_MIN;
            return hd;
        endfunction

        function longint heading_after(logic signed [15:0] rate);
            return heading_of(advance(yaw_acc, rate));
        endfunction

        function longint unit_clamp(longint m);
            if (m > UNITY) return UNITY;
            if (m < -UNITY) return -UNITY;
            return m;
        endfunction

        // Q2.30 side value to a forward/reverse duty pair
        function void split_duty(longint v, output logic [DUTY_BITS-1:0] fwd,
                                 output logic [DUTY_BITS-1:0] rev);
            longint mag;
            longint d;
            mag = (v < 0) ? -v : v;
            d   = (mag * DUTY_MAX) >> 30;
            if (d > DUTY_MAX) d = DUTY_MAX;
            fwd = '0;
            rev = '0;
            if (v > 0) fwd = d[DUTY_BITS-1:0];
            else if (v < 0) rev = d[DUTY_BITS-1:0];
        endfunction

        // Integrate one accepted tick and queue the drive it must produce
        function void note_request(logic op, logic signed [15:0] rate,
                                   logic signed [15:0] thr, logic signed [15:0] tgt);
            logic [ACC_W-1:0] next_acc;
            longint           hd;
            longint           err;
            longint           mul;
            longint           thr_l;
            longint           left_v;
            longint           right_v;
            drive_result_t    r;
            next_acc = advance(yaw_acc, rate);
            yaw_acc = next_acc;
            hd      = heading_of(yaw_acc);
            err     = longint'(tgt) - hd;
            thr_l   = longint'(thr);
            r.done  = 1'b0;
            if (op == OP_STRAIGHT) begin
                mul = unit_clamp((err * 7 * UNITY) / 25);
                if (thr_l > 0) begin
                    left_v  = thr_l * (UNITY + mul);
                    right_v = thr_l * (UNITY - mul);
                end else begin
                    left_v  = thr_l * (UNITY - mul);
                    right_v = thr_l * (UNITY + mul);
                end
            end else begin
                mul = unit_clamp((err * UNITY) / 18);
                if (mul > 0 && mul < MIN_SPIN) mul = MIN_SPIN;
                if (mul < 0 && mul > -MIN_SPIN) mul = -MIN_SPIN;
                if (err == 0) r.done = 1'b1;
                left_v  = mul * UNITY;
                right_v = -left_v;
            end
            split_duty(left_v, r.left_fwd, r.left_rev);
            split_duty(right_v, r.right_fwd, r.right_rev);
            r.heading = hd[15:0];
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [RES_W-1:0] td);
            drive_result_t got;
            drive_result_t want;
            got = td[$bits(drive_result_t)-1:0];
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding, expected none, got %h",
                         $time, td);
                return;
            end
            want = expected_q.pop_front();
            compare_field("left_forward_duty", want.left_fwd, got.left_fwd);
            compare_field("left_reverse_duty", want.left_rev, got.left_rev);
            compare_field("right_forward_duty", want.right_fwd, got.right_fwd);
            compare_field("right_reverse_duty", want.right_rev, got.right_rev);
            compare_field("heading", longint'(want.heading), longint'(got.heading));
            compare_field("turn_done", want.done, got.done);
        endfunction
    endclass

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [15:0]      cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [47:0]      s_tdata     = '0;   // [15:0] gyro_rate, [31:16] throttle, [47:32] target_angle
    logic             s_tuser     = 1'b0; // [0] op
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    // from bit 0 up: left fwd, left rev, right fwd, right rev duty, heading, turn_done, pad
    logic [RES_W-1:0] m_tdata;

    drive_scoreboard sb = new();

    bit idle_on       = 1'b1;  // random gaps on both sides
    bit hold_off_req  = 1'b0;  // ask the receiver for one long hold-off
    int quiet_cycles  = 0;

    always #4 aclk = ~aclk;

    gyro_heading_hold_drive_unit #(
        .DUTY_BITS(DUTY_BITS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Offer one request and hold it until the block takes it; note it at that edge
    task automatic send_request(input logic op, input logic [15:0] rate,
                                input logic [15:0] thr, input logic [15:0] tgt);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tgt, thr, rate};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, rate, thr, tgt);
    endtask

    // Drop valid for a random burst now and then
    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // Target near the heading this tick will produce, saturated to 16 bits
    function automatic logic [15:0] aim(logic [15:0] rate, int offset);
        longint t;
        t = sb.heading_after(rate) + offset;
        if (t > HEAD_MAX) t = HEAD_MAX;
        if (t < HEAD_MIN) t = HEAD_MIN;
        return t[15:0];
    endfunction

    // Write time_step with nothing in flight, so the step change lands between ticks
    task automatic write_step(input logic [15:0] v);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        sb.set_step(v);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_request();
        logic        op;
        logic [15:0] rate;
        logic [15:0] thr;
        logic [15:0] tgt;
        int          pick;
        op   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        // mostly gentle rates so the heading wanders rather than runs off
        if (pick < 5) rate = 16'($signed($urandom_range(0, 127)) - 64);
        else if (pick < 7) rate = '0;
        else rate = 16'($urandom);
        pick = $urandom_range(0, 9);
        case (pick)
            0:       thr = 16'h7FFF;
            1:       thr = 16'h8000;
            2:       thr = 16'(int'($urandom_range(0, 2)) - 1);
            default: thr = 16'($urandom);
        endcase
        // hold the error within 30 of zero most of the time
        if ($urandom_range(0, 9) < 7) tgt = aim(rate, int'($urandom_range(0, 60)) - 30);
        else tgt = 16'($urandom);
        sender_gap();
        send_request(op, rate, thr, tgt);
    endtask

    // Receiver: random stalls, one long hold-off on request, none in the last part
    initial begin : ready_drive
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check every accepted result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // Abort when neither side has moved a request for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("gyro_heading_hold_drive_unit verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] step_set [6];
        logic [15:0] spin;
        logic [15:0] tgt;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Straight mode, level heading: even drive, both throttle signs, zero throttle
        send_request(OP_STRAIGHT, 16'h0000, 16'h7FFF, 16'h0000);
        send_request(OP_STRAIGHT, 16'h0000, 16'h8000, 16'h0000);
        send_request(OP_STRAIGHT, 16'h0000, 16'h0000, 16'h0005);
        // small errors skew the sides; the skew swaps for reverse throttle
        send_request(OP_STRAIGHT, 16'h0000, 16'h7FFF, 16'h0001);
        send_request(OP_STRAIGHT, 16'h0000, 16'h8000, 16'hFFFF);
        send_request(OP_STRAIGHT, 16'h0000, 16'h8000, 16'h0002);
        send_request(OP_STRAIGHT, 16'h0000, 16'hFFFF, 16'h0003);
        // correction clamped to full scale, target extremes
        send_request(OP_STRAIGHT, 16'h0000, 16'h7FFF, 16'h7FFF);
        send_request(OP_STRAIGHT, 16'h0000, 16'h0001, 16'h8000);
        // gyro rate extremes move the heading
        send_request(OP_STRAIGHT, 16'h7FFF, 16'h4000, 16'h0000);
        send_request(OP_STRAIGHT, 16'h8000, 16'h4000, 16'h0000);
        send_request(OP_STRAIGHT, 16'h8000, 16'hC000, 16'h0000);
        // Turn mode: zero error raises done and stops both sides
        send_request(OP_TURN, 16'h0000, 16'h7FFF, aim(16'h0000, 0));
        // tiny errors are lifted to the minimum spin, larger ones scale then clamp
        send_request(OP_TURN, 16'h0000, 16'h8000, aim(16'h0000, 1));
        send_request(OP_TURN, 16'h0000, 16'h1234, aim(16'h0000, -1));
        send_request(OP_TURN, 16'h0000, 16'h0000, aim(16'h0000, 2));
        send_request(OP_TURN, 16'h0000, 16'h0000, aim(16'h0000, 3));
        send_request(OP_TURN, 16'h0000, 16'h0000, aim(16'h0000, -17));
        send_request(OP_TURN, 16'h0000, 16'h0000, aim(16'h0000, 18));
        send_request(OP_TURN, 16'h0000, 16'h0000, 16'h7FFF);
        send_request(OP_TURN, 16'h0000, 16'h0000, 16'h8000);
        // done on a heading the same tick has just moved
        send_request(OP_TURN, 16'h7FFF, 16'h0000, aim(16'h7FFF, 0));

        // Random ticks over several time steps: default, smallest, largest, zero, mid, any
        step_set = '{16'd655, 16'd1, 16'hFFFF, 16'd0, 16'h8000, 16'd0};
        step_set[5] = 16'($urandom_range(1, 65535));
        for (int p = 0; p < 6; p++) begin
            write_step(step_set[p]);
            idle_on = (p != 3);
            for (int i = 0; i < RANDOM_PER_SET; i++) begin
                // hold the receiver off while requests keep coming, to back the block up
                if (p == 1 && i == 40) hold_off_req = 1'b1;
                // pause the sender until the block has drained completely
                if (p == 2 && i == 60) begin
                    s_tvalid <= 1'b0;
                    while (sb.pending() != 0) @(posedge aclk);
                end
                random_request();
            end
        end

        // Last part, no idling: spin hard one way until the heading pins at its
        // negative limit, then back the other way past the positive limit
        write_step(16'hFFFF);
        idle_on = 1'b0;
        for (int i = 0; i < SPIN_UP + SPIN_BACK; i++) begin
            spin = (i < SPIN_UP) ? 16'h7FFF : 16'h8000;
            if ($urandom_range(0, 1) == 0) tgt = aim(spin, int'($urandom_range(0, 4)) - 2);
            else tgt = 16'($urandom);
            send_request(1'($urandom_range(0, 1)), spin, 16'($urandom), tgt);
        end
        s_tvalid <= 1'b0;

        // Drain, then allow the pipeline's latency to settle
        while (sb.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("gyro_heading_hold_drive_unit verification clean");
        end else begin
            $display("gyro_heading_hold_drive_unit verification failed");
        end
        $finish;
    end

endmodule
